FILE: rtl/prtc_pkg.sv
// package for the pump run timer controller
// holds field widths, codes, reset values and the item, result and config structs
// no dependencies
`default_nettype none

package prtc_pkg;

    // field widths
    localparam int unsigned TIME_W = 27;
    localparam int unsigned VOL_W  = 20;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned CAUSE_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // register reset values
    localparam logic [TIME_W-1:0] MAX_RUN_RESET = TIME_W'(300000);
    localparam logic [VOL_W-1:0]  MAX_VOL_RESET = VOL_W'(100000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOL = 1'b1;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_START_MAN  = 3'd1,
        OP_START_TIME = 3'd2,
        OP_START_VOL  = 3'd3,
        OP_STOP       = 3'd4,
        OP_ENABLE     = 3'd5,
        OP_DISABLE    = 3'd6,
        OP_VOL_UPDATE = 3'd7
    } t_op;

    // run modes
    typedef enum logic [MODE_W-1:0] {
        RUN_MANUAL = 2'd0,
        RUN_TIMED  = 2'd1,
        RUN_VOLUME = 2'd2
    } t_mode;

    // stop causes
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_UNSAFE    = 3'd1,
        CAUSE_TIME_DONE = 3'd2,
        CAUSE_VOL_DONE  = 3'd3,
        CAUSE_MAX_RUN   = 3'd4,
        CAUSE_COMMAND   = 3'd5
    } t_cause;

    // one command item
    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  duration_ms;
        logic [VOL_W-1:0]   volume_ml;
        logic               link_ok;
    } t_item;

    // one result item
    typedef struct packed {
        logic               accepted;
        logic               relay_on;
        t_mode              mode;
        t_cause             stop_cause;
        logic [TIME_W-1:0]  run_time_ms;
        logic [TIME_W-1:0]  remaining_ms;
        logic               enabled_flag;
        logic [VOL_W-1:0]   volume_now_ml;
    } t_result;

    // configuration registers
    typedef struct packed {
        logic [TIME_W-1:0]  max_run_ms;
        logic [VOL_W-1:0]   max_volume_ml;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/prtc_cfg_regs.sv
// configuration registers of the pump run timer controller
// depends on prtc_pkg
`default_nettype none

module prtc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [prtc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [prtc_pkg::TIME_W-1:0]      i_cfg_data,
    output prtc_pkg::t_cfg                        o_cfg
);

    logic [prtc_pkg::TIME_W-1:0] r_max_run_ms;
    logic [prtc_pkg::VOL_W-1:0]  r_max_volume_ml;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run_ms    <= prtc_pkg::MAX_RUN_RESET;
            r_max_volume_ml <= prtc_pkg::MAX_VOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prtc_pkg::CFG_MAX_RUN: r_max_run_ms    <= i_cfg_data;
                prtc_pkg::CFG_MAX_VOL: r_max_volume_ml <= i_cfg_data[prtc_pkg::VOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.max_run_ms    = r_max_run_ms;
    assign o_cfg.max_volume_ml = r_max_volume_ml;

endmodule

`default_nettype wire

FILE: rtl/prtc_core.sv
// pump run state and combinational next-state command update
// depends on prtc_pkg
`default_nettype none

module prtc_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  prtc_pkg::t_item   i_item,
    input  prtc_pkg::t_cfg    i_cfg,
    output prtc_pkg::t_result o_result
);

    // run state
    logic                        r_running;
    prtc_pkg::t_mode             r_mode;
    logic [prtc_pkg::TIME_W-1:0] r_elapsed;
    logic [prtc_pkg::TIME_W-1:0] r_limit;
    logic [prtc_pkg::VOL_W-1:0]  r_target;
    logic [prtc_pkg::VOL_W-1:0]  r_delivered;
    logic                        r_enabled;

    logic                        n_running;
    prtc_pkg::t_mode             n_mode;
    logic [prtc_pkg::TIME_W-1:0] n_elapsed;
    logic [prtc_pkg::TIME_W-1:0] n_limit;
    logic [prtc_pkg::VOL_W-1:0]  n_target;
    logic [prtc_pkg::VOL_W-1:0]  n_delivered;
    logic                        n_enabled;

    logic                        accepted;
    prtc_pkg::t_cause            cause;
    logic                        safe;
    logic                        halt;
    logic [prtc_pkg::TIME_W-1:0] elapsed_inc;
    logic [prtc_pkg::TIME_W-1:0] remaining;

    // saturating millisecond counter
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + prtc_pkg::TIME_W'(1);
    assign safe        = i_item.link_ok && r_enabled;

    // command decode and next state
    always_comb begin
        n_running   = r_running;
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_limit     = r_limit;
        n_target    = r_target;
        n_delivered = r_delivered;
        n_enabled   = r_enabled;
        accepted    = 1'b1;
        cause       = prtc_pkg::CAUSE_NONE;
        halt        = 1'b0;

        case (i_item.op)
            prtc_pkg::OP_TICK: begin
                if (r_running) begin
                    n_elapsed = elapsed_inc;
                    if (!safe)
                        cause = prtc_pkg::CAUSE_UNSAFE;
                    else if (r_mode == prtc_pkg::RUN_TIMED && elapsed_inc >= r_limit)
                        cause = prtc_pkg::CAUSE_TIME_DONE;
                    else if (r_mode == prtc_pkg::RUN_VOLUME && r_delivered >= r_target)
                        cause = prtc_pkg::CAUSE_VOL_DONE;
                    else if (elapsed_inc >= i_cfg.max_run_ms)
                        cause = prtc_pkg::CAUSE_MAX_RUN;
                    halt = (cause != prtc_pkg::CAUSE_NONE);
                end
            end
            prtc_pkg::OP_START_MAN: begin
                if (!safe) begin
                    accepted = 1'b0;
                end else if (!r_running) begin
                    n_running = 1'b1;
                    n_mode    = prtc_pkg::RUN_MANUAL;
                    n_elapsed = '0;
                    n_limit   = '0;
                    n_target  = '0;
                end
            end
            prtc_pkg::OP_START_TIME: begin
                if (i_item.duration_ms == '0 || i_item.duration_ms > i_cfg.max_run_ms
                        || !safe) begin
                    accepted = 1'b0;
                end else if (!r_running) begin
                    n_running = 1'b1;
                    n_mode    = prtc_pkg::RUN_TIMED;
                    n_elapsed = '0;
                    n_limit   = i_item.duration_ms;
                    n_target  = '0;
                end
            end
            prtc_pkg::OP_START_VOL: begin
                if (i_item.volume_ml == '0 || i_item.volume_ml > i_cfg.max_volume_ml
                        || !safe) begin
                    accepted = 1'b0;
                end else if (!r_running) begin
                    n_running   = 1'b1;
                    n_mode      = prtc_pkg::RUN_VOLUME;
                    n_elapsed   = '0;
                    n_limit     = '0;
                    n_target    = i_item.volume_ml;
                    n_delivered = '0;
                end
            end
            prtc_pkg::OP_STOP: begin
                if (r_running) begin
                    cause = prtc_pkg::CAUSE_COMMAND;
                    halt  = 1'b1;
                end
            end
            prtc_pkg::OP_ENABLE: begin
                n_enabled = 1'b1;
            end
            prtc_pkg::OP_DISABLE: begin
                n_enabled = 1'b0;
                if (r_running) begin
                    cause = prtc_pkg::CAUSE_COMMAND;
                    halt  = 1'b1;
                end
            end
            default: begin
                n_delivered = i_item.volume_ml;
            end
        endcase

        // stopping clears the whole run
        if (halt) begin
            n_running   = 1'b0;
            n_mode      = prtc_pkg::RUN_MANUAL;
            n_elapsed   = '0;
            n_limit     = '0;
            n_target    = '0;
            n_delivered = '0;
        end
    end

    // time left in a timed run
    assign remaining = (n_running && n_mode == prtc_pkg::RUN_TIMED && n_limit > n_elapsed)
                     ? n_limit - n_elapsed : '0;

    // state update on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_mode      <= prtc_pkg::RUN_MANUAL;
            r_elapsed   <= '0;
            r_limit     <= '0;
            r_target    <= '0;
            r_delivered <= '0;
            r_enabled   <= 1'b1;
        end else if (i_fire) begin
            r_running   <= n_running;
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
            r_limit     <= n_limit;
            r_target    <= n_target;
            r_delivered <= n_delivered;
            r_enabled   <= n_enabled;
        end
    end

    // result for the result register
    assign o_result.accepted      = accepted;
    assign o_result.relay_on      = n_running;
    assign o_result.mode          = n_mode;
    assign o_result.stop_cause    = cause;
    assign o_result.run_time_ms   = n_elapsed;
    assign o_result.remaining_ms  = remaining;
    assign o_result.enabled_flag  = n_enabled;
    assign o_result.volume_now_ml = n_delivered;

    // an idle pump carries no elapsed time, time limit, volume target or run mode
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_elapsed == '0 && r_limit == '0 && r_target == '0
                        && r_mode == prtc_pkg::RUN_MANUAL))
        else $error("idle pump holds run state");

    // only a timed run has a time limit
    a_limit_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running && r_mode != prtc_pkg::RUN_TIMED) |-> r_limit == '0)
        else $error("time limit outside timed run");

    // a reported stop leaves the pump off
    a_stop_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && cause != prtc_pkg::CAUSE_NONE) |=> !r_running)
        else $error("pump still running after stop");

    // a refused command changes no run state
    a_refuse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !accepted) |=> ($stable(r_running) && $stable(r_elapsed)
                                   && $stable(r_enabled)))
        else $error("refused command changed state");

endmodule

`default_nettype wire

FILE: rtl/pump_run_timer_controller_top.sv
// top level of the pump run timer controller: input register, result register, handshakes
// depends on prtc_pkg, prtc_cfg_regs and prtc_core
`default_nettype none

// Pump run timer controller. Takes one command item per clock on the input channel while
// ready is high, and returns exactly one result item per command on the output channel,
// in order. The item is held in an input register, then the run state is read and updated
// and the result captured in the result register; a stalled output holds the item in the
// input register. Sustained rate is one item per cycle while the output is not stalled,
// set by the read-modify-write of the run state. The result register frees the input side,
// so a new item is taken while an earlier result waits; ready only drops when both the
// input and result registers are full and the output is stalled. Configuration (max run
// time, max volume) is written through the plain write port and must only change while no
// item is in flight.
module pump_run_timer_controller_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [prtc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [prtc_pkg::TIME_W-1:0]      i_cfg_data,
    // command channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [prtc_pkg::OP_W-1:0]        i_op,
    input  wire logic [prtc_pkg::TIME_W-1:0]      i_duration_ms,
    input  wire logic [prtc_pkg::VOL_W-1:0]       i_volume_ml,
    input  wire logic                             i_link_ok,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_accepted,
    output logic                                  o_relay_on,
    output logic [prtc_pkg::MODE_W-1:0]           o_mode,
    output logic [prtc_pkg::CAUSE_W-1:0]          o_stop_cause,
    output logic [prtc_pkg::TIME_W-1:0]           o_run_time_ms,
    output logic [prtc_pkg::TIME_W-1:0]           o_remaining_ms,
    output logic                                  o_enabled_flag,
    output logic [prtc_pkg::VOL_W-1:0]            o_volume_now_ml
);

    prtc_pkg::t_cfg    cfg;
    prtc_pkg::t_item   r_item;
    prtc_pkg::t_result r_result;
    prtc_pkg::t_result core_result;
    logic              r_item_valid;
    logic              r_out_valid;
    logic              out_free;
    logic              item_move;

    // handshake control
    assign out_free   = !r_out_valid || i_out_ready;
    assign item_move  = r_item_valid && out_free;
    assign o_in_ready = !r_item_valid || item_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_in_ready)
                r_item_valid <= i_in_valid;
            if (out_free)
                r_out_valid <= r_item_valid;
        end
    end

    // input and result payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.op          <= prtc_pkg::t_op'(i_op);
            r_item.duration_ms <= i_duration_ms;
            r_item.volume_ml   <= i_volume_ml;
            r_item.link_ok     <= i_link_ok;
        end
        if (item_move)
            r_result <= core_result;
    end

    prtc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    prtc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (item_move),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // result ports
    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_result.accepted;
    assign o_relay_on      = r_result.relay_on;
    assign o_mode          = r_result.mode;
    assign o_stop_cause    = r_result.stop_cause;
    assign o_run_time_ms   = r_result.run_time_ms;
    assign o_remaining_ms  = r_result.remaining_ms;
    assign o_enabled_flag  = r_result.enabled_flag;
    assign o_volume_now_ml = r_result.volume_now_ml;

    // a result with a stop cause never shows the relay on
    a_cause_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stop_cause != prtc_pkg::CAUSE_NONE) |-> !o_relay_on)
        else $error("stop reported with relay on");

    // time left only in a running timed run
    a_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_remaining_ms != '0)
            |-> (o_relay_on && o_mode == prtc_pkg::RUN_TIMED))
        else $error("remaining time outside timed run");

    // a held item with a stalled output keeps the input closed
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("ready while both stages full");

endmodule

`default_nettype wire
